// ===== src/tsf_pkg.sv =====
package tsf_pkg;

    localparam int TIME_BITS = 32;

    localparam logic [2:0] M_OFF    = 3'd0;
    localparam logic [2:0] M_LANE_L = 3'd1;
    localparam logic [2:0] M_LANE_R = 3'd2;
    localparam logic [2:0] M_NORM_L = 3'd3;
    localparam logic [2:0] M_NORM_R = 3'd4;
    localparam logic [2:0] M_HAZ    = 3'd5;

    localparam logic [2:0] CFG_STEP     = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE = 3'd1;
    localparam logic [2:0] CFG_LONG     = 3'd2;
    localparam logic [2:0] CFG_HAZ_MIN  = 3'd3;
    localparam logic [2:0] CFG_LANE     = 3'd4;
    localparam logic [2:0] CFG_HAZ_HALF = 3'd5;
    localparam logic [2:0] CFG_GRACE    = 3'd6;

    // blink period = 511500 / (1023 + 9 * speed), quotient fits 9 bits
    localparam int DIVIDEND = 511500;
    localparam int DIV_BITS = 19;
    localparam int DEN_BITS = 14;
    localparam int QUO_BITS = 9;
    localparam int CNT_BITS = 5;

    typedef struct packed {
        logic div_start;
        logic step_go;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic step_done;
    } t_status;

endpackage

// ===== src/turn_signal_flasher_controller.sv =====
// flow: each input beat goes through the divide, step and wait states before the result beat
// the blink period comes from a 9-step divider that runs for every input beat
// one item at a time; the next is taken once the result beat has gone
// reset: synchronous active low, registers to defaults, block locked, time zero
module turn_signal_flasher_controller
    import tsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_left_level,
    input  logic        i_right_level,
    input  logic        i_hazard_level,
    input  logic [9:0]  i_speed_setting,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_left_lamp,
    output logic        o_right_lamp,
    output logic [2:0]  o_active_mode,
    output logic        o_left_held,
    output logic        o_right_held,
    output logic        o_hazard_held,
    output logic        o_is_locked,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    logic    load;

    assign o_cfg_ready = 1'b1;

    tsf_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_status(status), .o_cmd(cmd), .o_load(load)
    );

    tsf_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_cfg_we(i_cfg_valid), .i_cfg_index, .i_cfg_data, .i_load(load),
        .i_left_level, .i_right_level, .i_hazard_level, .i_speed_setting,
        .o_left_lamp, .o_right_lamp, .o_active_mode, .o_left_held,
        .o_right_held, .o_hazard_held, .o_is_locked
    );

endmodule

// ===== src/tsf_datapath.sv =====
module tsf_datapath
    import tsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_load,
    input  logic        i_left_level,
    input  logic        i_right_level,
    input  logic        i_hazard_level,
    input  logic [9:0]  i_speed_setting,
    output logic        o_left_lamp,
    output logic        o_right_lamp,
    output logic [2:0]  o_active_mode,
    output logic        o_left_held,
    output logic        o_right_held,
    output logic        o_hazard_held,
    output logic        o_is_locked
);

    typedef logic [TIME_BITS-1:0] t_time;

    logic [7:0]  r_step, r_deb;
    logic [15:0] r_long, r_hmin, r_lane, r_hhalf, r_grace;

    logic [2:0] r_lvl;

    t_time      r_now;
    t_time      r_st [6];
    logic [5:0] r_sl;
    logic [2:0] r_held;
    t_time      r_pt [3];
    t_time      r_rt [3];
    logic [2:0] r_src [3];
    logic [2:0] r_prev;
    logic [3:0] r_ltc [2];
    logic [1:0] r_lfc [2];
    t_time      r_ltt [2];
    t_time      r_btt [2];
    t_time      r_htt;
    logic [1:0] r_lamp;
    logic       r_locked;
    logic [2:0] r_usp, r_usr;
    logic [2:0] r_mode;
    logic       r_sdone;

    // shift-subtract divider for the blink period
    logic [DIV_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [QUO_BITS-1:0] r_quo;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy, r_ddone;
    logic [DIV_BITS-1:0] rem_sh;
    logic [DIV_BITS+QUO_BITS-1:0] den_sh;
    logic [DIV_BITS+QUO_BITS:0]   trial;

    always_comb begin
        rem_sh = r_rem;
        den_sh = {{(DIV_BITS+QUO_BITS-DEN_BITS){1'b0}}, r_den} << r_cnt;
        trial  = {{(QUO_BITS+1){1'b0}}, rem_sh} - {1'b0, den_sh};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_ddone <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_rem  <= DIV_BITS'(DIVIDEND);
                r_den  <= DEN_BITS'(14'd1023 + 14'(i_speed_setting) * 14'd9);
                r_quo  <= '0;
                r_cnt  <= CNT_BITS'(QUO_BITS - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!trial[DIV_BITS+QUO_BITS]) r_rem <= trial[DIV_BITS-1:0];
                r_quo <= {r_quo[QUO_BITS-2:0], ~trial[DIV_BITS+QUO_BITS]};
                if (r_cnt == '0) begin
                    r_busy  <= 1'b0;
                    r_ddone <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_status.div_done = r_ddone;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lvl   <= {i_hazard_level, i_right_level, i_left_level};
        end
    end

    function automatic t_time since(t_time now, t_time t);
        return now - t;
    endfunction

    always_ff @(posedge i_clk) begin
        logic       f;
        logic [2:0] mode;
        t_time      period;
        int         s;
        if (!i_rst_n) begin
            r_step <= 8'd10; r_deb <= 8'd20; r_long <= 16'd500; r_hmin <= 16'd200;
            r_lane <= 16'd100; r_hhalf <= 16'd500; r_grace <= 16'd100;
            r_now <= '0; r_sl <= '0; r_held <= '0; r_prev <= M_OFF;
            r_htt <= '0; r_lamp <= '0; r_locked <= 1'b1; r_usp <= '0; r_usr <= '0;
            r_mode <= M_OFF;
            for (int i = 0; i < 6; i++) r_st[i] <= '0;
            for (int i = 0; i < 3; i++) begin
                r_pt[i] <= '0; r_rt[i] <= '0; r_src[i] <= M_OFF;
            end
            for (int i = 0; i < 2; i++) begin
                r_ltc[i] <= '0; r_lfc[i] <= '0; r_ltt[i] <= '0; r_btt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STEP:     r_step  <= i_cfg_data[7:0];
                    CFG_DEBOUNCE: r_deb   <= i_cfg_data[7:0];
                    CFG_LONG:     r_long  <= i_cfg_data;
                    CFG_HAZ_MIN:  r_hmin  <= i_cfg_data;
                    CFG_LANE:     r_lane  <= i_cfg_data;
                    CFG_HAZ_HALF: r_hhalf <= i_cfg_data;
                    CFG_GRACE:    r_grace <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.step_go) begin
                // blocking copies give the sequential semantics of one step
                automatic t_time      st [6] = r_st;
                automatic logic [5:0] sl = r_sl;
                automatic logic [2:0] held = r_held;
                automatic t_time      pt [3] = r_pt;
                automatic t_time      rt [3] = r_rt;
                automatic logic [2:0] src [3] = r_src;
                automatic logic [3:0] ltc [2] = r_ltc;
                automatic logic [1:0] lfc [2] = r_lfc;
                automatic t_time      ltt [2] = r_ltt;
                automatic t_time      btt [2] = r_btt;
                automatic t_time      htt = r_htt;
                automatic logic [1:0] lamp = r_lamp;
                automatic logic       locked = r_locked;
                automatic logic [2:0] usp = r_usp, usr = r_usr;
                automatic logic       stop = 1'b0;
                mode = M_OFF;
                period = t_time'(r_quo);
                if (locked) begin
                    for (int b = 0; b < 3; b++) begin
                        if (!stop) begin
                            for (int t = 0; t < 2; t++) begin
                                if (since(r_now, st[b*2+t]) >= t_time'(r_deb)) begin
                                    f = (t == 0) ? (!sl[b*2+t] && r_lvl[b])
                                                 : (sl[b*2+t] && !r_lvl[b]);
                                    sl[b*2+t] = r_lvl[b];
                                    st[b*2+t] = r_now;
                                    if (f && t == 0) usp[b] = 1'b1;
                                    if (f && t == 1) usr[b] = 1'b1;
                                end
                            end
                            if (usp[b] && usr[b]) begin
                                locked = 1'b0;
                                stop = 1'b1;
                            end
                        end
                    end
                end else begin
                    for (int b = 0; b < 3; b++) begin
                        if (!held[b]) begin
                            if (since(r_now, st[b*2]) >= t_time'(r_deb)) begin
                                f = !sl[b*2] && r_lvl[b];
                                sl[b*2] = r_lvl[b]; st[b*2] = r_now;
                                if (f) begin held[b] = 1'b1; pt[b] = r_now; end
                            end
                        end else begin
                            if (b < 2 && since(r_now, pt[b]) >= t_time'(r_long))
                                src[b] = (b == 1) ? M_NORM_R : M_NORM_L;
                            if (since(r_now, st[b*2+1]) >= t_time'(r_deb)) begin
                                f = sl[b*2+1] && !r_lvl[b];
                                sl[b*2+1] = r_lvl[b]; st[b*2+1] = r_now;
                                if (f) begin
                                    held[b] = 1'b0;
                                    if (b < 2) begin
                                        if (since(r_now, pt[b]) < t_time'(r_long))
                                            src[b] = (b == 1) ? M_LANE_R : M_LANE_L;
                                    end else if (since(r_now, pt[b]) >= t_time'(r_hmin))
                                        src[b] = (src[b] == M_HAZ) ? M_OFF : M_HAZ;
                                    rt[b] = r_now;
                                end
                            end
                        end
                    end
                    mode = src[0];
                    if (src[1] > mode) mode = src[1];
                    if (src[2] > mode) mode = src[2];
                    if (src[0] == M_LANE_L && src[1] == M_LANE_R && src[2] != M_HAZ)
                        mode = (r_prev == M_LANE_L) ? M_LANE_R : M_LANE_L;
                    case (mode)
                        M_LANE_L, M_LANE_R: begin
                            s = (mode == M_LANE_R) ? 1 : 0;
                            if (r_prev != mode) begin
                                lamp[1-s] = 1'b0; ltc[s] = '0; lfc[s] = '0;
                            end
                            if (since(r_now, ltt[s]) >= t_time'(r_lane)) begin
                                if (ltc[s] == 4'd0) lamp[s] = 1'b1;
                                else if (ltc[s] == 4'd3) lamp[s] = 1'b0;
                                if (ltc[s] == 4'd9) begin
                                    ltc[s] = '0; lfc[s] = lfc[s] + 2'd1;
                                end else ltc[s] = ltc[s] + 4'd1;
                                ltt[s] = r_now;
                            end
                            if (lfc[s] == 2'd3) begin
                                lfc[s] = '0; ltc[s] = '0; src[s] = M_OFF;
                            end
                        end
                        M_NORM_L, M_NORM_R: begin
                            s = (mode == M_NORM_R) ? 1 : 0;
                            lamp[1-s] = 1'b0;
                            if (since(r_now, btt[s]) >= period) begin
                                lamp[s] = ~lamp[s]; btt[s] = r_now;
                            end
                            if (since(r_now, rt[s]) >= t_time'(r_grace) && !held[s])
                                src[s] = M_OFF;
                        end
                        M_HAZ: begin
                            if (r_prev != M_HAZ) lamp = '0;
                            if (since(r_now, htt) >= t_time'(r_hhalf)) begin
                                lamp = ~lamp; htt = r_now;
                            end
                        end
                        default: if (r_prev != M_OFF) lamp = '0;
                    endcase
                    if (mode != r_prev) begin
                        if (r_prev == M_LANE_L || r_prev == M_NORM_L) src[0] = M_OFF;
                        else if (r_prev == M_LANE_R || r_prev == M_NORM_R) src[1] = M_OFF;
                        else if (r_prev == M_HAZ) src[2] = M_OFF;
                    end
                    r_prev <= mode;
                end
                r_st <= st; r_sl <= sl; r_held <= held; r_pt <= pt; r_rt <= rt;
                r_src <= src; r_ltc <= ltc; r_lfc <= lfc; r_ltt <= ltt; r_btt <= btt;
                r_htt <= htt; r_lamp <= lamp; r_locked <= locked;
                r_usp <= usp; r_usr <= usr; r_mode <= mode;
                r_now <= r_now + t_time'(r_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sdone <= 1'b0;
        else          r_sdone <= i_cmd.step_go;
    end

    assign o_status.step_done = r_sdone;

    assign o_left_lamp   = r_lamp[0];
    assign o_right_lamp  = r_lamp[1];
    assign o_active_mode = r_mode;
    assign o_left_held   = r_held[0];
    assign o_right_held  = r_held[1];
    assign o_hazard_held = r_held[2];
    assign o_is_locked   = r_locked;

endmodule

// ===== src/tsf_ctrl.sv =====
module tsf_ctrl
    import tsf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_load
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_STEP = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_load        = o_in_ready && i_in_valid;
    assign o_out_valid   = (r_state == S_OUT);
    assign o_cmd.div_start = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.step_go   = (r_state == S_STEP);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_DIV;
            S_DIV:  if (i_status.div_done) n_state = S_STEP;
            S_STEP: n_state = S_WAIT;
            S_WAIT: if (i_status.step_done) n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// ===== dv/turn_signal_flasher_checker.sv =====
`timescale 1ns / 1ps
module turn_signal_flasher_checker
    import tsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        left_level,
    input  logic        right_level,
    input  logic        hazard_level,
    input  logic [9:0]  speed_setting,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        left_lamp,
    input  logic        right_lamp,
    input  logic [2:0]  active_mode,
    input  logic        left_held,
    input  logic        right_held,
    input  logic        hazard_held,
    input  logic        is_locked,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic       lamp_l;
        logic       lamp_r;
        logic [2:0] mode;
        logic       held_l;
        logic       held_r;
        logic       held_h;
        logic       locked;
    } t_lamp_state;

    typedef logic [TIME_BITS-1:0] t_ms;

    t_lamp_state expected_q[$];

    logic [7:0]  r_step, r_debounce;
    logic [15:0] r_long, r_haz_min, r_lane, r_haz_half, r_grace;

    t_ms        now_ms;
    t_ms        smp_time[6];
    logic       smp_level[6];
    logic       held[3];
    t_ms        press_at[3];
    t_ms        release_at[3];
    logic [2:0] src_mode[3];
    logic [2:0] prev_mode;
    logic [3:0] tick_cnt[2];
    logic [1:0] flash_cnt[2];
    t_ms        tick_at[2];
    t_ms        blink_at[2];
    t_ms        haz_at;
    logic       lamp[2];
    logic       locked;
    logic       seen_press[3];
    logic       seen_release[3];
    logic       btn[3];

    assign pending_count = expected_q.size();

    function automatic t_ms elapsed(t_ms t);
        return now_ms - t;
    endfunction

    function automatic logic sense_edge(int b, int test);
        int k;
        logic fired;
        k = b * 2 + test;
        fired = 1'b0;
        if (elapsed(smp_time[k]) >= r_debounce) begin
            fired = test == 0 ? (!smp_level[k] && btn[b]) : (smp_level[k] && !btn[b]);
            smp_level[k] = btn[b];
            smp_time[k] = now_ms;
        end
        return fired;
    endfunction

    task automatic clear_state();
        r_step = 8'd10; r_debounce = 8'd20; r_long = 16'd500; r_haz_min = 16'd200;
        r_lane = 16'd100; r_haz_half = 16'd500; r_grace = 16'd100;
        now_ms = '0; prev_mode = M_OFF; haz_at = '0; locked = 1'b1;
        for (int i = 0; i < 6; i++) begin
            smp_time[i] = '0; smp_level[i] = 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            held[i] = 0; press_at[i] = '0; release_at[i] = '0; src_mode[i] = M_OFF;
            seen_press[i] = 0; seen_release[i] = 0;
        end
        for (int i = 0; i < 2; i++) begin
            tick_cnt[i] = '0; flash_cnt[i] = '0; tick_at[i] = '0;
            blink_at[i] = '0; lamp[i] = 0;
        end
    endtask

    function automatic void side_button(int s);
        if (!held[s]) begin
            if (sense_edge(s, 0)) begin
                held[s] = 1; press_at[s] = now_ms;
            end
        end else begin
            if (elapsed(press_at[s]) >= r_long) src_mode[s] = s ? M_NORM_R : M_NORM_L;
            if (sense_edge(s, 1)) begin
                held[s] = 0;
                if (elapsed(press_at[s]) < r_long) src_mode[s] = s ? M_LANE_R : M_LANE_L;
                release_at[s] = now_ms;
            end
        end
    endfunction

    function automatic void lane_burst(int s, logic [2:0] mode);
        if (prev_mode != mode) begin
            lamp[s ^ 1] = 0; tick_cnt[s] = '0; flash_cnt[s] = '0;
        end
        if (elapsed(tick_at[s]) >= r_lane) begin
            if (tick_cnt[s] == 0) lamp[s] = 1;
            else if (tick_cnt[s] == 3) lamp[s] = 0;
            if (tick_cnt[s] == 9) begin
                tick_cnt[s] = '0; flash_cnt[s] = flash_cnt[s] + 1'b1;
            end else begin
                tick_cnt[s] = tick_cnt[s] + 1'b1;
            end
            tick_at[s] = now_ms;
        end
        if (flash_cnt[s] == 3) begin
            flash_cnt[s] = '0; tick_cnt[s] = '0; src_mode[s] = M_OFF;
        end
    endfunction

    function automatic void normal_blink(int s, logic [9:0] speed);
        int unsigned period;
        period = 511500 / (1023 + 9 * int'(speed));
        lamp[s ^ 1] = 0;
        if (elapsed(blink_at[s]) >= period) begin
            lamp[s] = !lamp[s]; blink_at[s] = now_ms;
        end
        if (elapsed(release_at[s]) >= r_grace && !held[s]) src_mode[s] = M_OFF;
    endfunction

    function automatic t_lamp_state next_lamps(logic l, logic r, logic h, logic [9:0] speed);
        logic [2:0] mode;
        t_lamp_state res;
        mode = M_OFF;
        btn[0] = l; btn[1] = r; btn[2] = h;
        if (locked) begin
            for (int b = 0; b < 3; b++) begin
                if (sense_edge(b, 0)) seen_press[b] = 1;
                if (sense_edge(b, 1)) seen_release[b] = 1;
                if (seen_press[b] && seen_release[b]) begin
                    locked = 0;
                    break;
                end
            end
        end else begin
            side_button(0);
            side_button(1);
            if (!held[2]) begin
                if (sense_edge(2, 0)) begin
                    held[2] = 1; press_at[2] = now_ms;
                end
            end else if (sense_edge(2, 1)) begin
                held[2] = 0; release_at[2] = now_ms;
                if (t_ms'(release_at[2] - press_at[2]) >= r_haz_min)
                    src_mode[2] = src_mode[2] == M_HAZ ? M_OFF : M_HAZ;
            end
            mode = src_mode[0];
            if (src_mode[1] > mode) mode = src_mode[1];
            if (src_mode[2] > mode) mode = src_mode[2];
            // two pending lane changes take turns
            if (src_mode[0] == M_LANE_L && src_mode[1] == M_LANE_R && src_mode[2] != M_HAZ)
                mode = prev_mode == M_LANE_L ? M_LANE_R : M_LANE_L;
            case (mode)
                M_LANE_L: lane_burst(0, mode);
                M_LANE_R: lane_burst(1, mode);
                M_NORM_L: normal_blink(0, speed);
                M_NORM_R: normal_blink(1, speed);
                M_HAZ: begin
                    if (prev_mode != M_HAZ) begin
                        lamp[0] = 0; lamp[1] = 0;
                    end
                    if (elapsed(haz_at) >= r_haz_half) begin
                        lamp[0] = !lamp[0]; lamp[1] = !lamp[1]; haz_at = now_ms;
                    end
                end
                default: begin
                    if (prev_mode != M_OFF) begin
                        lamp[0] = 0; lamp[1] = 0;
                    end
                end
            endcase
            if (mode != prev_mode) begin
                if (prev_mode == M_LANE_L || prev_mode == M_NORM_L) src_mode[0] = M_OFF;
                else if (prev_mode == M_LANE_R || prev_mode == M_NORM_R) src_mode[1] = M_OFF;
                else if (prev_mode == M_HAZ) src_mode[2] = M_OFF;
            end
            prev_mode = mode;
        end
        res = '{lamp[0], lamp[1], mode, held[0], held[1], held[2], locked};
        now_ms = now_ms + r_step;
        return res;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        clear_state();
    end

    always @(posedge i_clk) begin
        t_lamp_state want;
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STEP:     r_step = cfg_data[7:0];
                    CFG_DEBOUNCE: r_debounce = cfg_data[7:0];
                    CFG_LONG:     r_long = cfg_data;
                    CFG_HAZ_MIN:  r_haz_min = cfg_data;
                    CFG_LANE:     r_lane = cfg_data;
                    CFG_HAZ_HALF: r_haz_half = cfg_data;
                    CFG_GRACE:    r_grace = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_q.push_back(next_lamps(left_level, right_level, hazard_level,
                    speed_setting));
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected beat", 0, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (left_lamp !== want.lamp_l) report("left_lamp", left_lamp, want.lamp_l);
                    if (right_lamp !== want.lamp_r)
                        report("right_lamp", right_lamp, want.lamp_r);
                    if (active_mode !== want.mode) report("active_mode", active_mode, want.mode);
                    if (left_held !== want.held_l) report("left_held", left_held, want.held_l);
                    if (right_held !== want.held_r)
                        report("right_held", right_held, want.held_r);
                    if (hazard_held !== want.held_h)
                        report("hazard_held", hazard_held, want.held_h);
                    if (is_locked !== want.locked) report("is_locked", is_locked, want.locked);
                end
            end
        end
    end

endmodule

// ===== dv/turn_signal_flasher_controller_test.sv =====
`timescale 1ns / 1ps
module turn_signal_flasher_controller_test
    import tsf_pkg::*;
();

    logic        i_clk, i_rst_n;
    logic        in_valid, in_ready;
    logic        left_level, right_level, hazard_level;
    logic [9:0]  speed_setting;
    logic        out_valid, out_ready;
    logic        left_lamp, right_lamp, left_held, right_held, hazard_held, is_locked;
    logic [2:0]  active_mode;
    logic        cfg_valid, cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fail_count, pending_count;
    int          cycle_count;
    int          idle_pct;
    bit          hold_off;

    turn_signal_flasher_controller DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_left_level(left_level), .i_right_level(right_level),
        .i_hazard_level(hazard_level), .i_speed_setting(speed_setting),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_left_lamp(left_lamp), .o_right_lamp(right_lamp),
        .o_active_mode(active_mode), .o_left_held(left_held),
        .o_right_held(right_held), .o_hazard_held(hazard_held),
        .o_is_locked(is_locked),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    turn_signal_flasher_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .left_level(left_level), .right_level(right_level),
        .hazard_level(hazard_level), .speed_setting(speed_setting),
        .out_valid(out_valid), .out_ready(out_ready),
        .left_lamp(left_lamp), .right_lamp(right_lamp), .active_mode(active_mode),
        .left_held(left_held), .right_held(right_held), .hazard_held(hazard_held),
        .is_locked(is_locked),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) out_ready <= 1'b0;
        else if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic send_step(logic l, logic r, logic h, logic [9:0] speed);
        while ($urandom_range(99) < idle_pct) @(negedge i_clk);
        in_valid = 1'b1;
        left_level <= l; right_level <= r; hazard_level <= h; speed_setting <= speed;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    task automatic hold_buttons(logic l, logic r, logic h, int steps);
        for (int i = 0; i < steps; i++) send_step(l, r, h, 10'($urandom));
    endtask

    task automatic drain();
        while (pending_count != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_valid = 1'b1; cfg_index <= idx; cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_session(int steps);
        int n;
        logic [2:0] pat;
        n = 0;
        while (n < steps) begin
            int len;
            len = $urandom_range(1, 70);
            if ($urandom_range(9) < 8) begin
                // a press of one button (sometimes a random pattern), then release
                pat = 3'b001 << $urandom_range(2);
                if ($urandom_range(9) == 0) pat = 3'($urandom);
            end else begin
                pat = 3'($urandom);
            end
            hold_buttons(pat[0], pat[1], pat[2], len);
            hold_buttons(0, 0, 0, $urandom_range(1, 30));
            n += len;
        end
    endtask

    initial begin
        cycle_count = 0;
        idle_pct = 33;
        hold_off = 0;
        i_rst_n = 1'b0;
        in_valid = 0; left_level = 0; right_level = 0; hazard_level = 0;
        speed_setting = '0;
        cfg_valid = 0; cfg_index = CFG_STEP; cfg_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: unlock, lane taps, hazard, speed extremes
        hold_buttons(0, 0, 0, 3);
        hold_buttons(1, 0, 0, 4);
        hold_buttons(0, 0, 0, 3);
        send_step(1, 0, 0, 10'd0);
        send_step(1, 0, 0, 10'd1023);
        hold_buttons(0, 0, 0, 2);
        send_step(0, 1, 0, 10'd1023);
        send_step(0, 1, 1, 10'd0);
        hold_buttons(0, 0, 0, 3);
        send_step(0, 0, 1, 10'd512);
        send_step(0, 0, 0, 10'd511);
        drain();

        write_reg(CFG_STEP, 16'd50);
        write_reg(CFG_DEBOUNCE, 16'd20);
        write_reg(CFG_LONG, 16'd400);
        write_reg(CFG_HAZ_MIN, 16'd100);
        write_reg(CFG_LANE, 16'd50);
        write_reg(CFG_HAZ_HALF, 16'd200);
        write_reg(CFG_GRACE, 16'd100);
        random_session(60);
        drain();

        // extremes
        write_reg(CFG_STEP, 16'd255);
        write_reg(CFG_DEBOUNCE, 16'd1);
        write_reg(CFG_LONG, 16'd65535);
        write_reg(CFG_HAZ_MIN, 16'd0);
        write_reg(CFG_LANE, 16'd1);
        write_reg(CFG_HAZ_HALF, 16'd65535);
        write_reg(CFG_GRACE, 16'd0);
        random_session(30);

        // receiver holds off while the bench keeps offering steps
        fork
            begin
                hold_off = 1;
                repeat (200) @(negedge i_clk);
                hold_off = 0;
            end
            hold_buttons(1, 0, 0, 8);
        join
        drain();

        write_reg(CFG_STEP, 16'd1);
        write_reg(CFG_DEBOUNCE, 16'd255);
        write_reg(CFG_LONG, 16'd1);
        write_reg(CFG_HAZ_MIN, 16'd65535);
        write_reg(CFG_LANE, 16'd65535);
        write_reg(CFG_HAZ_HALF, 16'd1);
        write_reg(CFG_GRACE, 16'd65535);
        random_session(20);
        drain();

        write_reg(CFG_STEP, 16'd20);
        write_reg(CFG_DEBOUNCE, 16'd30);
        write_reg(CFG_LONG, 16'd300);
        write_reg(CFG_HAZ_MIN, 16'd60);
        write_reg(CFG_LANE, 16'd20);
        write_reg(CFG_HAZ_HALF, 16'd100);
        write_reg(CFG_GRACE, 16'd40);
        idle_pct = 0;
        random_session(40);
        idle_pct = 33;
        random_session(65);

        drain();
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
